/* sv/snc_pkg.sv */
`timescale 1ns / 1ps
// Shared definitions for the SPI NOR command sequencer.
// Holds mode and action codes, flash opcodes, queue sizing and result types.
package snc_pkg;

   localparam logic [2:0] MODE_STATUS = 3'd0;
   localparam logic [2:0] MODE_ID     = 3'd1;
   localparam logic [2:0] MODE_READ   = 3'd2;
   localparam logic [2:0] MODE_PROG   = 3'd3;
   localparam logic [2:0] MODE_ERASE  = 3'd4;
   localparam logic [2:0] MODE_WDATA  = 3'd5;
   localparam logic [2:0] MODE_RX     = 3'd6;

   localparam logic [2:0] ACT_SEL  = 3'd0;
   localparam logic [2:0] ACT_XCH  = 3'd1;
   localparam logic [2:0] ACT_REL  = 3'd2;
   localparam logic [2:0] ACT_VAL  = 3'd3;
   localparam logic [2:0] ACT_DONE = 3'd4;

   localparam logic [7:0] OP_RDSR  = 8'h05;
   localparam logic [7:0] OP_WREN  = 8'h06;
   localparam logic [7:0] OP_RDID  = 8'h90;
   localparam logic [7:0] OP_READ  = 8'h03;
   localparam logic [7:0] OP_PP    = 8'h02;
   localparam logic [7:0] OP_SE    = 8'h20;
   localparam logic [7:0] OP_DUMMY = 8'hFF;
   localparam logic [7:0] OP_ZERO  = 8'h00;

   localparam logic [15:0] PAGE_BYTES = 16'd256;

   localparam int GRP_MAX   = 3;
   localparam int RSP_DEPTH = 8;
   localparam int RSP_PTR_W = $clog2(RSP_DEPTH);
   localparam int RSP_CNT_W = $clog2(RSP_DEPTH + 1);

   typedef struct packed {
      logic [2:0]  action;
      logic [7:0]  tx_byte;
      logic [15:0] value;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic [1:0]              cnt;
      rsp_type [GRP_MAX-1:0]   res;
   } grp_type;

endpackage

/* sv/snc_seq.sv */
`timescale 1ns / 1ps
// Command sequencer state machine: turns one accepted request into up to three results.
// Depends on snc_pkg for codes, opcodes and the result group type.
module snc_seq (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  logic [2:0]        req_mode,
   input  logic [23:0]       req_address,
   input  logic [15:0]       req_length,
   input  logic [7:0]        req_write_byte,
   input  logic [7:0]        req_rx_byte,
   output snc_pkg::grp_type  grp
);
   import snc_pkg::*;

   typedef enum logic [3:0] {
      PH_IDLE, PH_DATA_WAIT, PH_STAT_CMD, PH_STAT_RD, PH_ID_HDR, PH_ID_RD, PH_CMD,
      PH_RD_DATA, PH_PRE_CMD, PH_PRE_RD, PH_WREN, PH_PROG_BYTE, PH_POST_CMD, PH_POST_RD
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [2:0]  op_ff, op_in;
   logic [23:0] addr_ff, addr_in;
   logic [15:0] left_ff, left_in;
   logic [1:0]  step_ff, step_in;
   logic [7:0]  idh_ff, idh_in;
   logic [15:0] left_dec;
   logic [7:0]  addr_byte;
   logic [1:0]  n;
   rsp_type [GRP_MAX-1:0] res;

   function automatic rsp_type mk(input logic [2:0] act, input logic [7:0] tx,
                                  input logic [15:0] val);
      rsp_type r;
      r.action  = act;
      r.tx_byte = tx;
      r.value   = val;
      r.last    = 1'b0;
      return r;
   endfunction

   assign left_dec = left_ff - 16'd1;

   always_comb begin
      case (step_ff)
         2'd0:    addr_byte = addr_ff[23:16];
         2'd1:    addr_byte = addr_ff[15:8];
         default: addr_byte = addr_ff[7:0];
      endcase
   end

   always_comb begin
      phase_in = phase_ff;
      op_in    = op_ff;
      addr_in  = addr_ff;
      left_in  = left_ff;
      step_in  = step_ff;
      idh_in   = idh_ff;
      n        = 2'd0;
      res      = '0;
      if (phase_ff == PH_IDLE && req_mode <= MODE_ERASE) begin
         op_in   = req_mode;
         addr_in = req_address;
         step_in = 2'd0;
         left_in = 16'd0;
         res[0]  = mk(ACT_SEL, OP_ZERO, 16'd0);
         n       = 2'd2;
         unique case (req_mode)
            MODE_STATUS: begin
               res[1]   = mk(ACT_XCH, OP_RDSR, 16'd0);
               phase_in = PH_STAT_CMD;
            end
            MODE_ID: begin
               res[1]   = mk(ACT_XCH, OP_RDID, 16'd0);
               phase_in = PH_ID_HDR;
            end
            MODE_READ: begin
               left_in  = req_length;
               res[1]   = mk(ACT_XCH, OP_READ, 16'd0);
               phase_in = PH_CMD;
            end
            default: begin
               if (req_mode == MODE_PROG) begin
                  left_in = (req_length > PAGE_BYTES) ? PAGE_BYTES : req_length;
               end
               res[1]   = mk(ACT_XCH, OP_RDSR, 16'd0);
               phase_in = PH_PRE_CMD;
            end
         endcase
      end else if (req_mode == MODE_WDATA && phase_ff == PH_DATA_WAIT) begin
         res[0]   = mk(ACT_XCH, req_write_byte, 16'd0);
         n        = 2'd1;
         phase_in = PH_PROG_BYTE;
      end else if (req_mode == MODE_RX) begin
         unique case (phase_ff)
            PH_STAT_CMD, PH_PRE_CMD, PH_POST_CMD: begin
               res[0] = mk(ACT_XCH, OP_DUMMY, 16'd0);
               n      = 2'd1;
               if (phase_ff == PH_STAT_CMD) begin
                  phase_in = PH_STAT_RD;
               end else if (phase_ff == PH_PRE_CMD) begin
                  phase_in = PH_PRE_RD;
               end else begin
                  phase_in = PH_POST_RD;
               end
            end
            PH_STAT_RD: begin
               res[0]   = mk(ACT_REL, OP_ZERO, 16'd0);
               res[1]   = mk(ACT_VAL, OP_ZERO, {8'd0, req_rx_byte});
               res[2]   = mk(ACT_DONE, OP_ZERO, 16'd0);
               n        = 2'd3;
               phase_in = PH_IDLE;
            end
            PH_ID_HDR: begin
               n = 2'd1;
               if (step_ff != 2'd3) begin
                  res[0]  = mk(ACT_XCH, OP_ZERO, 16'd0);
                  step_in = step_ff + 2'd1;
               end else begin
                  res[0]   = mk(ACT_XCH, OP_DUMMY, 16'd0);
                  step_in  = 2'd0;
                  phase_in = PH_ID_RD;
               end
            end
            PH_ID_RD: begin
               if (step_ff == 2'd0) begin
                  idh_in  = req_rx_byte;
                  step_in = 2'd1;
                  res[0]  = mk(ACT_XCH, OP_DUMMY, 16'd0);
                  n       = 2'd1;
               end else begin
                  res[0]   = mk(ACT_REL, OP_ZERO, 16'd0);
                  res[1]   = mk(ACT_VAL, OP_ZERO, {idh_ff, req_rx_byte});
                  res[2]   = mk(ACT_DONE, OP_ZERO, 16'd0);
                  n        = 2'd3;
                  step_in  = 2'd0;
                  phase_in = PH_IDLE;
               end
            end
            PH_PRE_RD, PH_POST_RD: begin
               res[0] = mk(ACT_REL, OP_ZERO, 16'd0);
               if (req_rx_byte[0]) begin
                  res[1]   = mk(ACT_SEL, OP_ZERO, 16'd0);
                  res[2]   = mk(ACT_XCH, OP_RDSR, 16'd0);
                  n        = 2'd3;
                  phase_in = (phase_ff == PH_PRE_RD) ? PH_PRE_CMD : PH_POST_CMD;
               end else if (phase_ff == PH_PRE_RD) begin
                  res[1]   = mk(ACT_SEL, OP_ZERO, 16'd0);
                  res[2]   = mk(ACT_XCH, OP_WREN, 16'd0);
                  n        = 2'd3;
                  phase_in = PH_WREN;
               end else begin
                  res[1]   = mk(ACT_DONE, OP_ZERO, 16'd0);
                  n        = 2'd2;
                  phase_in = PH_IDLE;
               end
            end
            PH_WREN: begin
               res[0]   = mk(ACT_REL, OP_ZERO, 16'd0);
               res[1]   = mk(ACT_SEL, OP_ZERO, 16'd0);
               res[2]   = mk(ACT_XCH, (op_ff == MODE_PROG) ? OP_PP : OP_SE, 16'd0);
               n        = 2'd3;
               step_in  = 2'd0;
               phase_in = PH_CMD;
            end
            PH_CMD: begin
               if (step_ff != 2'd3) begin
                  res[0]  = mk(ACT_XCH, addr_byte, 16'd0);
                  n       = 2'd1;
                  step_in = step_ff + 2'd1;
               end else begin
                  step_in = 2'd0;
                  if (op_ff == MODE_READ) begin
                     if (left_ff != 16'd0) begin
                        res[0]   = mk(ACT_XCH, OP_DUMMY, 16'd0);
                        n        = 2'd1;
                        phase_in = PH_RD_DATA;
                     end else begin
                        res[0]   = mk(ACT_REL, OP_ZERO, 16'd0);
                        res[1]   = mk(ACT_DONE, OP_ZERO, 16'd0);
                        n        = 2'd2;
                        phase_in = PH_IDLE;
                     end
                  end else if (op_ff == MODE_PROG && left_ff != 16'd0) begin
                     phase_in = PH_DATA_WAIT;
                  end else begin
                     res[0]   = mk(ACT_REL, OP_ZERO, 16'd0);
                     res[1]   = mk(ACT_SEL, OP_ZERO, 16'd0);
                     res[2]   = mk(ACT_XCH, OP_RDSR, 16'd0);
                     n        = 2'd3;
                     phase_in = PH_POST_CMD;
                  end
               end
            end
            PH_RD_DATA: begin
               res[0]  = mk(ACT_VAL, OP_ZERO, {8'd0, req_rx_byte});
               left_in = left_dec;
               if (left_dec != 16'd0) begin
                  res[1] = mk(ACT_XCH, OP_DUMMY, 16'd0);
                  n      = 2'd2;
               end else begin
                  res[1]   = mk(ACT_REL, OP_ZERO, 16'd0);
                  res[2]   = mk(ACT_DONE, OP_ZERO, 16'd0);
                  n        = 2'd3;
                  phase_in = PH_IDLE;
               end
            end
            PH_PROG_BYTE: begin
               left_in = left_dec;
               if (left_dec != 16'd0) begin
                  phase_in = PH_DATA_WAIT;
               end else begin
                  res[0]   = mk(ACT_REL, OP_ZERO, 16'd0);
                  res[1]   = mk(ACT_SEL, OP_ZERO, 16'd0);
                  res[2]   = mk(ACT_XCH, OP_RDSR, 16'd0);
                  n        = 2'd3;
                  phase_in = PH_POST_CMD;
               end
            end
            default: begin
               phase_in = phase_ff;
            end
         endcase
      end
      if (n != 2'd0) begin
         res[n - 2'd1].last = 1'b1;
      end
   end

   assign grp.cnt = accept ? n : 2'd0;
   assign grp.res = res;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         op_ff    <= 3'd0;
         addr_ff  <= 24'd0;
         left_ff  <= 16'd0;
         step_ff  <= 2'd0;
         idh_ff   <= 8'd0;
      end else if (accept) begin
         phase_ff <= phase_in;
         op_ff    <= op_in;
         addr_ff  <= addr_in;
         left_ff  <= left_in;
         step_ff  <= step_in;
         idh_ff   <= idh_in;
      end
   end

endmodule

/* sv/snc_rsp_fifo.sv */
`timescale 1ns / 1ps
// Result queue: takes a group of up to three results per cycle, hands out one per cycle while rsp_stall is low.
// Depends on snc_pkg for the result types and queue sizing.
module snc_rsp_fifo (
   input  logic              clock,
   input  logic              reset,
   input  snc_pkg::grp_type  grp,
   output logic              room,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output snc_pkg::rsp_type  head
);
   import snc_pkg::*;

   rsp_type                mem_ff [RSP_DEPTH];
   logic [RSP_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [RSP_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [RSP_CNT_W-1:0]   count_ff, count_in;
   logic                   pop;

   assign rsp_valid = (count_ff != '0);
   assign pop       = rsp_valid && !rsp_stall;
   assign room      = (count_ff <= RSP_CNT_W'(RSP_DEPTH - GRP_MAX));
   assign head      = mem_ff[rd_ptr_ff];

   assign wr_ptr_in = wr_ptr_ff + RSP_PTR_W'(grp.cnt);
   assign rd_ptr_in = rd_ptr_ff + RSP_PTR_W'(pop);
   assign count_in  = count_ff + RSP_CNT_W'(grp.cnt) - RSP_CNT_W'(pop);

   always_ff @(posedge clock) begin
      for (int i = 0; i < GRP_MAX; i++) begin
         if (i < int'(grp.cnt)) begin
            mem_ff[wr_ptr_ff + RSP_PTR_W'(i)] <= grp.res[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

/* sv/spi_nor_command_sequencer.sv */
`timescale 1ns / 1ps
// SPI NOR command sequencer top level: sequencer state machine and result queue.
// The results of a request enter the result queue at the clock edge that accepts it.
// Throughput: one request per cycle while the eight-entry result queue holds at most five;
// results leave at one per cycle while rsp_stall is low, so three-result requests are paced by the queue output.
// Reset: synchronous; clears the sequencer to idle and empties the result queue.
// Depends on snc_pkg, snc_seq and snc_rsp_fifo.
module spi_nor_command_sequencer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_mode,
   input  logic [23:0] req_address,
   input  logic [15:0] req_length,
   input  logic [7:0]  req_write_byte,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_action,
   output logic [7:0]  rsp_tx_byte,
   output logic [15:0] rsp_value,
   output logic        rsp_last
);
   import snc_pkg::*;

   grp_type grp;
   rsp_type head;
   logic    room;
   logic    accept;

   assign req_stall = !room;
   assign accept    = req_valid && room;

   snc_seq u_seq (
      .clock          (clock),
      .reset          (reset),
      .accept         (accept),
      .req_mode       (req_mode),
      .req_address    (req_address),
      .req_length     (req_length),
      .req_write_byte (req_write_byte),
      .req_rx_byte    (req_rx_byte),
      .grp            (grp)
   );

   snc_rsp_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .grp       (grp),
      .room      (room),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .head      (head)
   );

   assign rsp_action  = head.action;
   assign rsp_tx_byte = head.tx_byte;
   assign rsp_value   = head.value;
   assign rsp_last    = head.last;

endmodule

/* sv/snc_checker.sv */
`timescale 1ns / 1ps
// Port-level checks for the SPI NOR command sequencer, bound to its top level.
// Depends on snc_pkg for mode and action codes.
module snc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic [2:0]  req_mode,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [2:0]  rsp_action,
   input logic [7:0]  rsp_tx_byte,
   input logic [15:0] rsp_value,
   input logic        rsp_last
);
   import snc_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_action) && $stable(rsp_tx_byte)
         && $stable(rsp_value) && $stable(rsp_last))
      else $error("Stalled response changed.");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("Response offered right after reset.");

   a_first_status: assert property (@(posedge clock) disable iff (reset)
      $past(reset) && req_valid && !req_stall && req_mode == MODE_STATUS
         |=> rsp_valid && rsp_action == ACT_SEL && !rsp_last)
      else $error("Status request after reset did not start with select.");

   a_done_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_action == ACT_DONE |-> rsp_last)
      else $error("Done is not the final response of its request.");

   a_value_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_action != ACT_VAL |-> rsp_value == 16'd0)
      else $error("Value field set on a non-value response.");

endmodule

bind spi_nor_command_sequencer snc_checker u_snc_checker (.*);

/* test/tb_spi_nor_command_sequencer.sv */
`timescale 1ns / 1ps
// Testbench for spi_nor_command_sequencer: drives host requests and flash bytes with random gaps
// and stalls, predicts every action in a scoreboard class, and checks each result in order.
// Depends on snc_pkg and the spi_nor_command_sequencer RTL.
module tb_spi_nor_command_sequencer;
   import snc_pkg::*;

   localparam logic [2:0] MODE_UNUSED = 3'd7;

   typedef enum logic [3:0] {
      PH_IDLE, PH_DATA_WAIT, PH_STAT_CMD, PH_STAT_RD, PH_ID_HDR, PH_ID_RD, PH_CMD,
      PH_RD_DATA, PH_PRE_CMD, PH_PRE_RD, PH_WREN, PH_PROG_BYTE, PH_POST_CMD, PH_POST_RD
   } seq_phase_type;

   class flash_cmd_scoreboard;
      seq_phase_type phase = PH_IDLE;
      logic [2:0]  op = MODE_STATUS;
      logic [23:0] target = '0;
      logic [15:0] left = '0;
      int          steps = 0;
      logic [7:0]  id_high = '0;
      rsp_type     pending[$];
      int          errors = 0;

      function void push_action(logic [2:0] act, logic [7:0] tx, logic [15:0] val);
         rsp_type r;
         r.action = act;
         r.tx_byte = tx;
         r.value = val;
         r.last = 1'b0;
         pending.push_back(r);
      endfunction

      function void start_poll(seq_phase_type next);
         push_action(ACT_SEL, OP_ZERO, '0);
         push_action(ACT_XCH, OP_RDSR, '0);
         phase = next;
      endfunction

      function void take_request(logic [2:0] mode, logic [23:0] addr, logic [15:0] len,
                                 logic [7:0] wb, logic [7:0] rx);
         int      first;
         rsp_type r;
         first = pending.size();
         if (phase == PH_IDLE && mode <= MODE_ERASE) begin
            op = mode;
            target = addr;
            steps = 0;
            left = '0;
            case (mode)
               MODE_STATUS: begin
                  push_action(ACT_SEL, OP_ZERO, '0);
                  push_action(ACT_XCH, OP_RDSR, '0);
                  phase = PH_STAT_CMD;
               end
               MODE_ID: begin
                  push_action(ACT_SEL, OP_ZERO, '0);
                  push_action(ACT_XCH, OP_RDID, '0);
                  phase = PH_ID_HDR;
               end
               MODE_READ: begin
                  left = len;
                  push_action(ACT_SEL, OP_ZERO, '0);
                  push_action(ACT_XCH, OP_READ, '0);
                  phase = PH_CMD;
               end
               default: begin
                  if (mode == MODE_PROG) left = (len > PAGE_BYTES) ? PAGE_BYTES : len;
                  start_poll(PH_PRE_CMD);
               end
            endcase
         end else if (mode == MODE_WDATA && phase == PH_DATA_WAIT) begin
            push_action(ACT_XCH, wb, '0);
            phase = PH_PROG_BYTE;
         end else if (mode == MODE_RX) begin
            case (phase)
               PH_STAT_CMD: begin
                  push_action(ACT_XCH, OP_DUMMY, '0);
                  phase = PH_STAT_RD;
               end
               PH_STAT_RD: begin
                  push_action(ACT_REL, OP_ZERO, '0);
                  push_action(ACT_VAL, OP_ZERO, {8'h00, rx});
                  push_action(ACT_DONE, OP_ZERO, '0);
                  phase = PH_IDLE;
               end
               PH_ID_HDR: begin
                  if (steps < 3) begin
                     push_action(ACT_XCH, OP_ZERO, '0);
                     steps++;
                  end else begin
                     push_action(ACT_XCH, OP_DUMMY, '0);
                     steps = 0;
                     phase = PH_ID_RD;
                  end
               end
               PH_ID_RD: begin
                  if (steps == 0) begin
                     id_high = rx;
                     steps = 1;
                     push_action(ACT_XCH, OP_DUMMY, '0);
                  end else begin
                     push_action(ACT_REL, OP_ZERO, '0);
                     push_action(ACT_VAL, OP_ZERO, {id_high, rx});
                     push_action(ACT_DONE, OP_ZERO, '0);
                     steps = 0;
                     phase = PH_IDLE;
                  end
               end
               PH_PRE_CMD: begin
                  push_action(ACT_XCH, OP_DUMMY, '0);
                  phase = PH_PRE_RD;
               end
               PH_PRE_RD: begin
                  push_action(ACT_REL, OP_ZERO, '0);
                  if (rx[0]) begin
                     start_poll(PH_PRE_CMD);
                  end else begin
                     push_action(ACT_SEL, OP_ZERO, '0);
                     push_action(ACT_XCH, OP_WREN, '0);
                     phase = PH_WREN;
                  end
               end
               PH_WREN: begin
                  push_action(ACT_REL, OP_ZERO, '0);
                  push_action(ACT_SEL, OP_ZERO, '0);
                  push_action(ACT_XCH, (op == MODE_PROG) ? OP_PP : OP_SE, '0);
                  steps = 0;
                  phase = PH_CMD;
               end
               PH_CMD: begin
                  if (steps < 3) begin
                     push_action(ACT_XCH, target[(2 - steps) * 8 +: 8], '0);
                     steps++;
                  end else begin
                     steps = 0;
                     if (op == MODE_READ) begin
                        if (left != '0) begin
                           push_action(ACT_XCH, OP_DUMMY, '0);
                           phase = PH_RD_DATA;
                        end else begin
                           push_action(ACT_REL, OP_ZERO, '0);
                           push_action(ACT_DONE, OP_ZERO, '0);
                           phase = PH_IDLE;
                        end
                     end else if (op == MODE_PROG && left != '0) begin
                        phase = PH_DATA_WAIT;
                     end else begin
                        push_action(ACT_REL, OP_ZERO, '0);
                        start_poll(PH_POST_CMD);
                     end
                  end
               end
               PH_RD_DATA: begin
                  push_action(ACT_VAL, OP_ZERO, {8'h00, rx});
                  left = left - 16'd1;
                  if (left != '0) begin
                     push_action(ACT_XCH, OP_DUMMY, '0);
                  end else begin
                     push_action(ACT_REL, OP_ZERO, '0);
                     push_action(ACT_DONE, OP_ZERO, '0);
                     phase = PH_IDLE;
                  end
               end
               PH_PROG_BYTE: begin
                  left = left - 16'd1;
                  if (left != '0) begin
                     phase = PH_DATA_WAIT;
                  end else begin
                     push_action(ACT_REL, OP_ZERO, '0);
                     start_poll(PH_POST_CMD);
                  end
               end
               PH_POST_CMD: begin
                  push_action(ACT_XCH, OP_DUMMY, '0);
                  phase = PH_POST_RD;
               end
               PH_POST_RD: begin
                  push_action(ACT_REL, OP_ZERO, '0);
                  if (rx[0]) begin
                     start_poll(PH_POST_CMD);
                  end else begin
                     push_action(ACT_DONE, OP_ZERO, '0);
                     phase = PH_IDLE;
                  end
               end
               default: ;
            endcase
         end
         if (pending.size() > first) begin
            r = pending.pop_back();
            r.last = 1'b1;
            pending.push_back(r);
         end
      endfunction

      function void check_action(logic [2:0] act, logic [7:0] tx, logic [15:0] val, logic lst);
         rsp_type e;
         if (pending.size() == 0) begin
            $error("action %0d arrived with nothing expected", act);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (act !== e.action) begin
            $error("action: expected %0d, got %0d", e.action, act);
            errors++;
         end
         if (tx !== e.tx_byte) begin
            $error("tx_byte: expected %02h, got %02h", e.tx_byte, tx);
            errors++;
         end
         if (val !== e.value) begin
            $error("value: expected %04h, got %04h", e.value, val);
            errors++;
         end
         if (lst !== e.last) begin
            $error("last: expected %0b, got %0b", e.last, lst);
            errors++;
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [2:0]  req_mode = MODE_UNUSED;
   logic [23:0] req_address = '0;
   logic [15:0] req_length = '0;
   logic [7:0]  req_write_byte = '0;
   logic [7:0]  req_rx_byte = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [2:0]  rsp_action;
   logic [7:0]  rsp_tx_byte;
   logic [15:0] rsp_value;
   logic        rsp_last;

   flash_cmd_scoreboard sb;
   bit req_calm = 1'b0;
   bit rsp_calm = 1'b0;
   int useful_items = 0;

   spi_nor_command_sequencer dut (.*);

   always #6 clock = ~clock;

   task automatic issue(input logic [2:0] mode, input logic [23:0] addr, input logic [15:0] len,
                        input logic [7:0] wb, input logic [7:0] rx);
      int gap;
      gap = req_calm ? 0 : $urandom_range(0, 14);
      if ($urandom_range(0, 39) == 0) req_calm = !req_calm;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_mode <= mode;
      req_address <= addr;
      req_length <= len;
      req_write_byte <= wb;
      req_rx_byte <= rx;
      do @(posedge clock); while (req_stall !== 1'b0);
      sb.take_request(mode, addr, len, wb, rx);
      @(negedge clock);
   endtask

   task automatic finish_op(input int busy_each, input int noise_pct);
      int         busy_run;
      logic [7:0] rx;
      busy_run = 0;
      while (sb.phase != PH_IDLE) begin
         rx = 8'($urandom);
         if ($urandom_range(0, 99) < noise_pct) begin
            issue(3'($urandom), 24'($urandom), 16'($urandom), 8'($urandom), rx);
         end else begin
            if (sb.phase == PH_PRE_RD || sb.phase == PH_POST_RD) begin
               rx[0] = (busy_run < busy_each);
               busy_run = rx[0] ? busy_run + 1 : 0;
            end
            useful_items++;
            issue((sb.phase == PH_DATA_WAIT) ? MODE_WDATA : MODE_RX, 24'($urandom),
                  16'($urandom), 8'($urandom), rx);
         end
      end
   endtask

   task automatic run_op(input logic [2:0] mode, input logic [23:0] addr, input logic [15:0] len,
                         input int busy_each, input int noise_pct);
      useful_items++;
      issue(mode, addr, len, 8'($urandom), 8'($urandom));
      finish_op(busy_each, noise_pct);
   endtask

   initial begin : result_sink
      int hold;
      while (reset) @(negedge clock);
      forever begin
         hold = rsp_calm ? 0 : $urandom_range(0, 14);
         if ($urandom_range(0, 39) == 0) rsp_calm = !rsp_calm;
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(negedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (rsp_valid !== 1'b1);
         sb.check_action(rsp_action, rsp_tx_byte, rsp_value, rsp_last);
         @(negedge clock);
      end
   end

   initial begin : stimulus
      int          kind;
      logic [2:0]  mode;
      logic [15:0] len;
      sb = new;
      repeat (5) @(negedge clock);
      reset <= 1'b0;

      issue(MODE_UNUSED, 24'($urandom), 16'($urandom), 8'($urandom), 8'($urandom));
      issue(MODE_WDATA, 24'($urandom), 16'($urandom), 8'hFF, 8'($urandom));
      issue(MODE_RX, 24'($urandom), 16'($urandom), 8'($urandom), 8'hFF);
      run_op(MODE_STATUS, 24'($urandom), 16'($urandom), 0, 0);
      run_op(MODE_ID, 24'($urandom), 16'($urandom), 0, 0);
      run_op(MODE_READ, 24'hFFFFFF, 16'd0, 0, 0);
      useful_items++;
      issue(MODE_READ, 24'h000000, 16'd2, 8'h00, 8'h00);
      issue(MODE_STATUS, 24'($urandom), 16'($urandom), 8'($urandom), 8'($urandom));
      issue(MODE_UNUSED, 24'($urandom), 16'($urandom), 8'($urandom), 8'($urandom));
      finish_op(0, 0);
      run_op(MODE_PROG, 24'h000000, 16'd0, 0, 0);
      useful_items++;
      issue(MODE_PROG, 24'hA5A5A5, 16'd1, 8'($urandom), 8'($urandom));
      issue(MODE_WDATA, 24'($urandom), 16'($urandom), 8'($urandom), 8'($urandom));
      finish_op(2, 0);
      run_op(MODE_ERASE, 24'h5A5A5A, 16'hFFFF, 1, 0);
      run_op(MODE_PROG, 24'($urandom), 16'hFFFF, 0, 0);

      useful_items = 0;
      while (useful_items < 210) begin
         kind = $urandom_range(0, 11);
         if (kind == 0) begin
            issue(3'($urandom_range(5, 7)), 24'($urandom), 16'($urandom), 8'($urandom),
                  8'($urandom));
         end else begin
            mode = 3'($urandom_range(0, 4));
            if (mode == MODE_READ)
               len = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(6, 40))
                                                 : 16'($urandom_range(0, 5));
            else if (mode == MODE_PROG)
               len = 16'($urandom_range(0, 6));
            else
               len = 16'($urandom);
            run_op(mode, 24'($urandom), len, $urandom_range(0, 2),
                   ($urandom_range(0, 3) == 0) ? 15 : 0);
         end
      end
      req_valid <= 1'b0;

      while (sb.pending.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
      if (sb.errors == 0)
         $display("tb_spi_nor_command_sequencer: clean");
      else
         $display("tb_spi_nor_command_sequencer: errors");
      $finish;
   end

   initial begin : watchdog
      #10_000_000;
      $display("tb_spi_nor_command_sequencer: errors");
      $finish;
   end

endmodule
